[design/tagreg_pkg.sv]
package tagreg_pkg;

  // Field widths of one item
  localparam int UID_LO_W = 64;
  localparam int UID_HI_W = 16;
  localparam int UID_LEN_W = 4;
  localparam int TIME_W = 32;
  localparam int COUNT_W = 16;
  localparam int COOL_W = 16;
  localparam int STATUS_W = 3;

  localparam logic [COOL_W-1:0] COOLDOWN_RESET = 16'd200;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COOLDOWN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd4;

  // One table entry as held in the memory
  typedef struct packed {
    logic [UID_LEN_W-1:0] len;
    logic [UID_LO_W-1:0]  lo;
    logic [UID_HI_W-1:0]  hi;
    logic [COUNT_W-1:0]   count;
    logic [TIME_W-1:0]    seen;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_APPEND,
    S_DONE
  } state_t;

endpackage

[design/tag_registry_with_cooldown.sv]
// Tag registry with cooldown.
// Input channel (in_*): one tap or preload request per transfer; in_tuser is the
// mode (0 tap, 1 preload), in_tdata carries the identifier, its length and the time.
// Output channel (out_*): one result per request; out_tuser is the status,
// out_tdata carries the one-based entry id and the entry's visit count.
// Config channel (cfg_*): writes the 16-bit cooldown in ms, always ready; write it
// only while no request is in flight.
// All entries live in one synchronous memory (one write port, one read port,
// registered read). A request walks the used entries one per cycle in
// order; the first read is issued in the accepting cycle. The walk stops at the
// first hit or, on a miss, after the last used entry; then follow one update or
// append step and one step that loads the result into the output register.
// A new request is taken as soon as the previous result sits in the output register,
// even while the receiver stalls; its finished result then waits until the output
// register frees up.
// Reset (rst_n low, synchronous) empties the table by clearing the
// fill count, sets the cooldown to 200 ms and drops any pending result.
module tag_registry_with_cooldown #(
  parameter int TABLE_DEPTH = 512,
  parameter int MAX_ID_BYTES = 10,
  localparam int ID_W = $clog2(TABLE_DEPTH + 1),
  localparam int OUT_W = ((ID_W + tagreg_pkg::COUNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write: cooldown_ms
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tagreg_pkg::COOL_W-1:0]   cfg_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: uid_low[63:0], uid_high[79:64], uid_len[83:80], now_ms[115:84], zero pad
  input  logic [119:0]                    in_tdata,
  // tuser: mode
  input  logic                            in_tuser,
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: entry_id[ID_W-1:0], visit_count above it, zero pad
  output logic [OUT_W-1:0]                out_tdata,
  // tuser: status
  output logic [tagreg_pkg::STATUS_W-1:0] out_tuser
);

  import tagreg_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [UID_LEN_W-1:0] MAX_LEN = UID_LEN_W'(MAX_ID_BYTES);
  localparam logic [ID_W-1:0] DEPTH_CNT = ID_W'(TABLE_DEPTH);

  // Entry memory
  entry_t entry_mem [TABLE_DEPTH];
  entry_t rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;
  logic wr_en;

  // Control
  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [ID_W-1:0] used_r, used_nxt;
  logic [COOL_W-1:0] cooldown_r;

  // Request payload
  logic mode_r;
  logic [UID_LO_W-1:0] key_lo_r;
  logic [UID_HI_W-1:0] key_hi_r;
  logic [UID_LEN_W-1:0] key_len_r;
  logic [TIME_W-1:0] now_r;
  entry_t ent_r;

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0] res_id_r, res_id_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;
  logic out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0] out_id_r;
  logic [COUNT_W-1:0] out_count_r;
  logic out_load;

  // Decoded and masked input key
  logic [UID_LEN_W-1:0] in_len_raw;
  logic [UID_LEN_W-1:0] in_len_sat;
  logic [UID_LO_W-1:0] in_lo_mask;
  logic [UID_HI_W-1:0] in_hi_mask;
  logic in_accept;
  logic hit;
  logic [TIME_W-1:0] elapsed;
  logic [IDX_W-1:0] idx_inc;
  logic [ID_W-1:0] idx_id;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Saturate the length and build byte masks
  assign in_len_raw = in_tdata[83:80];
  assign in_len_sat = (in_len_raw > MAX_LEN) ? MAX_LEN : in_len_raw;

  always_comb begin
    for (int b = 0; b < UID_LO_W / 8; b++) begin
      in_lo_mask[b*8 +: 8] = (UID_LEN_W'(b) < in_len_sat) ? 8'hFF : 8'h00;
    end
    for (int b = 0; b < UID_HI_W / 8; b++) begin
      in_hi_mask[b*8 +: 8] = (UID_LEN_W'(b + UID_LO_W / 8) < in_len_sat) ? 8'hFF : 8'h00;
    end
  end

  // Compare the entry read last cycle against the key
  assign hit = (rd_data_r.len == key_len_r) && (rd_data_r.lo == key_lo_r) &&
               (rd_data_r.hi == key_hi_r);
  assign elapsed = now_r - ent_r.seen;
  assign idx_inc = idx_r + 1'b1;
  assign idx_id = ID_W'(idx_r) + 1'b1;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= entry_mem[rd_addr];
  end

  // Next state, memory access and result
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    used_nxt = used_r;
    rd_addr = idx_inc;
    wr_en = 1'b0;
    wr_addr = idx_r;
    wr_data = ent_r;
    res_status_nxt = res_status_r;
    res_id_nxt = res_id_r;
    res_count_nxt = res_count_r;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_accept) begin
          idx_nxt = '0;
          state_nxt = (used_r == '0) ? S_APPEND : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt = S_UPDATE;
        end else if (idx_id == used_r) begin
          state_nxt = S_APPEND;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_UPDATE: begin
        res_id_nxt = idx_id;
        res_count_nxt = ent_r.count;
        if (mode_r) begin
          res_status_nxt = ST_PRESENT;
        end else if (elapsed < TIME_W'(cooldown_r)) begin
          res_status_nxt = ST_COOLDOWN;
        end else begin
          // bump count unless saturated and stamp the time
          wr_en = 1'b1;
          if (ent_r.count != '1) begin
            wr_data.count = ent_r.count + 1'b1;
          end
          wr_data.seen = now_r;
          res_status_nxt = ST_COUNTED;
          res_count_nxt = wr_data.count;
        end
        state_nxt = S_DONE;
      end
      S_APPEND: begin
        if (used_r == DEPTH_CNT) begin
          res_status_nxt = ST_FULL;
          res_id_nxt = '0;
          res_count_nxt = '0;
        end else begin
          wr_en = 1'b1;
          wr_addr = used_r[IDX_W-1:0];
          wr_data.len = key_len_r;
          wr_data.lo = key_lo_r;
          wr_data.hi = key_hi_r;
          wr_data.count = mode_r ? '0 : COUNT_W'(1);
          wr_data.seen = mode_r ? '0 : now_r;
          used_nxt = used_r + 1'b1;
          res_status_nxt = ST_ADDED;
          res_id_nxt = used_r + 1'b1;
          res_count_nxt = wr_data.count;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      used_r <= '0;
      cooldown_r <= COOLDOWN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      used_r <= used_nxt;
      if (cfg_valid && cfg_ready) begin
        cooldown_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_tuser;
      key_lo_r <= in_tdata[63:0] & in_lo_mask;
      key_hi_r <= in_tdata[79:64] & in_hi_mask;
      key_len_r <= in_len_sat;
      now_r <= in_tdata[115:84];
    end
    if (state_r == S_SEARCH && hit) begin
      ent_r <= rd_data_r;
    end
    res_status_r <= res_status_nxt;
    res_id_r <= res_id_nxt;
    res_count_r <= res_count_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r <= res_id_r;
      out_count_r <= res_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_status_r;
  assign out_tdata = OUT_W'({out_count_r, out_id_r});

  // Fill count stays within the table
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_CNT)
    else $error("fill count beyond table depth");

  // Fill count only grows by one, and only from an append
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (used_r != $past(used_r)) |->
      (used_r == $past(used_r) + 1'b1) && ($past(state_r) == S_APPEND))
    else $error("fill count changed outside an append");

  // Scan never walks past the used entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (idx_id <= used_r))
    else $error("scan index beyond used entries");

  // A full-table result names no entry
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> (out_id_r == '0) && (out_count_r == '0))
    else $error("table full result carries an entry");

  // Writes happen only in the update or append step
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_UPDATE) || (state_r == S_APPEND))
    else $error("memory write outside update or append");

endmodule
